// File: src/pfrf_pkg.sv
// Shared constants, operation codes and memory port types of the page framebuffer.
package pfrf_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_ROWS     = 8;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
    localparam int STORE_DEPTH   = SCREEN_WIDTH * PAGE_COUNT;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int BIT_W  = $clog2(PAGE_ROWS);
    // signed span of origin plus size, wide enough for every screen size in range
    localparam int SPAN_W = 11;

    typedef enum logic [1:0] {
        OP_FILL  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } store_rd_t;

endpackage

// File: src/pfrf_store.sv
// Frame store: single write port, one registered read port.
module pfrf_store import pfrf_pkg::*;
(
    input  logic       clk,
    input  store_wr_t  wr,
    input  store_rd_t  rd,
    output logic [7:0] rd_data
);

    logic [7:0] frame_mem [STORE_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            frame_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= frame_mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/page_framebuffer_rect_fill_top.sv
// Top level of the page-packed monochrome framebuffer with rectangle fill.
//
// The framebuffer holds SCREEN_WIDTH x SCREEN_HEIGHT pixels as pages of eight
// rows, one byte per column per page, byte index page * SCREEN_WIDTH + column,
// bit n being row page*8+n. All pixel state sits in one single-port-write
// memory with a registered read. After reset the block sweeps all STORE_DEPTH
// bytes (1024 at 128x64) to zero, one byte per cycle, before it takes its
// first transaction. A fill clips the rectangle to the screen and
// read-modify-writes one page byte per cycle over the covered columns of
// each covered page, then writes back the last byte; an empty fill and
// operation code 3 change nothing and leave the block idle.
// A clear sweeps the memory to zero again. A read returns one transaction
// with the byte, or zero for an index past the store; it waits while an
// earlier result is still stalled. Fill, clear and a following read may
// proceed while an earlier read result is still held on the result side.
module page_framebuffer_rect_fill_top import pfrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              item_valid,
    output logic              item_stall,
    input  logic [1:0]        operation,
    input  logic signed [8:0] rect_x,
    input  logic signed [8:0] rect_y,
    input  logic [7:0]        rect_width,
    input  logic [7:0]        rect_height,
    input  logic              pixel_on,
    input  logic [9:0]        read_index,

    output logic              result_valid,
    input  logic              result_stall,
    output logic [7:0]        read_byte
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_FILL  = 4'b0100,
        S_READ  = 4'b1000
    } state_t;

    localparam logic signed [SPAN_W-1:0] WIDTH_S  = SPAN_W'(SCREEN_WIDTH);
    localparam logic signed [SPAN_W-1:0] HEIGHT_S = SPAN_W'(SCREEN_HEIGHT);
    localparam logic [ADDR_W-1:0]        LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [ADDR_W-1:0]        PAGE_STEP = ADDR_W'(SCREEN_WIDTH);

    // control state
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    logic              wb_valid_reg, wb_valid_next;
    logic              result_valid_reg, result_valid_next;

    // fill walk and write-back payload
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  col_first_reg, col_first_next;
    logic [COL_W-1:0]  col_last_reg, col_last_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [PAGE_W-1:0] page_last_reg, page_last_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [SPAN_W-1:0] row_lo_reg, row_lo_next;
    logic [SPAN_W-1:0] row_hi_reg, row_hi_next;
    logic              on_reg, on_next;
    logic [ADDR_W-1:0] wb_addr_reg, wb_addr_next;
    logic [7:0]        wb_mask_reg, wb_mask_next;
    logic              oob_reg, oob_next;
    logic [7:0]        read_byte_reg, read_byte_next;

    logic              accept;
    logic              result_taken;
    logic              result_load;

    logic signed [SPAN_W-1:0] x_start, y_start, x_end, y_end;
    logic signed [SPAN_W-1:0] x_lo, x_hi, y_lo, y_hi;
    logic signed [SPAN_W-1:0] x_last, y_last;
    logic                     fill_empty;
    logic [PAGE_W-1:0]        page_first;
    logic [7:0]               page_mask;

    store_wr_t  store_wr;
    store_rd_t  store_rd;
    logic [7:0] store_data;

    pfrf_store u_store
    (
        .clk     (clk),
        .wr      (store_wr),
        .rd      (store_rd),
        .rd_data (store_data)
    );

    // Take a new transaction only when idle and no write-back is in flight,
    // so a read never races the last write of a fill.
    assign item_stall   = (state_reg != S_IDLE) || wb_valid_reg;
    assign accept       = item_valid && !item_stall;
    assign result_taken = result_valid_reg && !result_stall;
    assign result_load  = (state_reg == S_READ) && (!result_valid_reg || !result_stall);

    assign result_valid = result_valid_reg;
    assign read_byte    = read_byte_reg;

    // Clip the rectangle to the screen.
    always_comb
    begin
        x_start = SPAN_W'(rect_x);
        y_start = SPAN_W'(rect_y);
        x_end   = x_start + $signed(SPAN_W'(rect_width));
        y_end   = y_start + $signed(SPAN_W'(rect_height));
        x_lo    = (x_start < 0) ? '0 : x_start;
        y_lo    = (y_start < 0) ? '0 : y_start;
        x_hi    = (x_end > WIDTH_S) ? WIDTH_S : x_end;
        y_hi    = (y_end > HEIGHT_S) ? HEIGHT_S : y_end;
        x_last  = x_hi - SPAN_W'(1);
        y_last  = y_hi - SPAN_W'(1);
        fill_empty = (x_lo >= x_hi) || (y_lo >= y_hi);
        page_first = PAGE_W'(y_lo >>> BIT_W);
    end

    // Bits of the current page that fall inside the clipped row range.
    always_comb
    begin
        logic [SPAN_W-1:0] row;
        page_mask = '0;
        for (int n = 0; n < PAGE_ROWS; n++)
        begin
            row = SPAN_W'({page_reg, BIT_W'(n)});
            page_mask[n] = (row >= row_lo_reg) && (row < row_hi_reg);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        sweep_next        = sweep_reg;
        wb_valid_next     = 1'b0;
        result_valid_next = result_valid_reg;

        col_next       = col_reg;
        col_first_next = col_first_reg;
        col_last_next  = col_last_reg;
        page_next      = page_reg;
        page_last_next = page_last_reg;
        base_next      = base_reg;
        row_lo_next    = row_lo_reg;
        row_hi_next    = row_hi_reg;
        on_next        = on_reg;
        wb_addr_next   = wb_addr_reg;
        wb_mask_next   = wb_mask_reg;
        oob_next       = oob_reg;
        read_byte_next = read_byte_reg;

        store_rd.en   = 1'b0;
        store_rd.addr = base_reg + ADDR_W'(col_reg);

        // Drop the result once taken; a fresh load below wins.
        if (result_taken)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(operation))
                        OP_FILL:
                        begin
                            if (!fill_empty)
                            begin
                                col_first_next = COL_W'(x_lo);
                                col_next       = COL_W'(x_lo);
                                col_last_next  = COL_W'(x_last);
                                page_next      = page_first;
                                page_last_next = PAGE_W'(y_last >>> BIT_W);
                                base_next      = ADDR_W'(ADDR_W'(page_first) * PAGE_STEP);
                                row_lo_next    = y_lo;
                                row_hi_next    = y_hi;
                                on_next        = pixel_on;
                                state_next     = S_FILL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = S_CLEAR;
                        end
                        OP_READ:
                        begin
                            store_rd.en   = 1'b1;
                            store_rd.addr = ADDR_W'(read_index);
                            oob_next      = !(32'(read_index) < 32'(STORE_DEPTH));
                            state_next    = S_READ;
                        end
                        OP_NONE:
                        begin
                            state_next = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                // Read one page byte, modify and write it back next cycle.
                store_rd.en   = 1'b1;
                wb_valid_next = 1'b1;
                wb_addr_next  = base_reg + ADDR_W'(col_reg);
                wb_mask_next  = page_mask;
                if (col_reg == col_last_reg)
                begin
                    col_next = col_first_reg;
                    if (page_reg == page_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        page_next = page_reg + PAGE_W'(1);
                        base_next = base_reg + PAGE_STEP;
                    end
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            S_READ:
            begin
                // Hold the fetched byte until the result register is free.
                if (result_load)
                begin
                    read_byte_next    = oob_reg ? 8'd0 : store_data;
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Write port: sweep zeros during a clear, else the fill write-back.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            store_wr.en   = 1'b1;
            store_wr.addr = sweep_reg;
            store_wr.data = 8'd0;
        end
        else
        begin
            store_wr.en   = wb_valid_reg;
            store_wr.addr = wb_addr_reg;
            store_wr.data = on_reg ? (store_data | wb_mask_reg)
                                   : (store_data & ~wb_mask_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            sweep_reg        <= '0;
            wb_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            wb_valid_reg     <= wb_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        col_first_reg <= col_first_next;
        col_last_reg  <= col_last_next;
        page_reg      <= page_next;
        page_last_reg <= page_last_next;
        base_reg      <= base_next;
        row_lo_reg    <= row_lo_next;
        row_hi_reg    <= row_hi_next;
        on_reg        <= on_next;
        wb_addr_reg   <= wb_addr_next;
        wb_mask_reg   <= wb_mask_next;
        oob_reg       <= oob_next;
        read_byte_reg <= read_byte_next;
    end

endmodule

// File: src/pfrf_checker.sv
// Port-level assertions for the framebuffer top level, and their bind.
module pfrf_checker import pfrf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic [1:0] operation,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] read_byte
);

    logic [1:0] pending_reg, pending_next;
    logic       read_in;
    logic       result_out;

    assign read_in    = item_valid && !item_stall && (operation == OP_READ);
    assign result_out = result_valid && !result_stall;

    // Track reads accepted whose byte has not yet been taken.
    always_comb
    begin
        pending_next = pending_reg + 2'(read_in) - 2'(result_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(read_byte))
        else $error("stalled result changed or vanished");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result offered during reset");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pending_reg != 2'd0)
        else $error("result without an outstanding read");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        read_in |=> item_stall)
        else $error("transaction taken while a read is in flight");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("more than two reads outstanding");

endmodule

bind page_framebuffer_rect_fill_top pfrf_checker u_pfrf_checker (.*);
